[hdl/i2cm_pkg.sv]
// i2cm_pkg: shared types and codes of the I2C master register controller.
// No dependencies; compiled before the interfaces and the top level.
`default_nettype none

package i2cm_pkg;

  // register width of the data, control and status registers
  localparam int unsigned RegW  = 8;
  localparam int unsigned BaudW = 7;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_DONE  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // register offsets divided by four
  localparam logic [2:0] IDX_DATA  = 3'd1;
  localparam logic [2:0] IDX_CTRL  = 3'd2;
  localparam logic [2:0] IDX_STAT  = 3'd3;
  localparam logic [2:0] IDX_SRST  = 3'd7;

  // control register bit positions
  localparam int unsigned CTL_ACK   = 2;
  localparam int unsigned CTL_IFLG  = 3;
  localparam int unsigned CTL_STOP  = 4;
  localparam int unsigned CTL_START = 5;

  // status codes
  localparam logic [RegW-1:0] ST_START   = 8'h08;
  localparam logic [RegW-1:0] ST_RSTART  = 8'h10;
  localparam logic [RegW-1:0] ST_ADDR_W  = 8'h18;
  localparam logic [RegW-1:0] ST_ADDR_WN = 8'h20;
  localparam logic [RegW-1:0] ST_DATA_W  = 8'h28;
  localparam logic [RegW-1:0] ST_DATA_WN = 8'h30;
  localparam logic [RegW-1:0] ST_ADDR_R  = 8'h40;
  localparam logic [RegW-1:0] ST_ADDR_RN = 8'h48;
  localparam logic [RegW-1:0] ST_DATA_R  = 8'h50;
  localparam logic [RegW-1:0] ST_DATA_RN = 8'h58;
  localparam logic [RegW-1:0] ST_IDLE    = 8'hF8;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_START  = 3'd1,
    PH_RSTART = 3'd2,
    PH_ADDR   = 3'd3,
    PH_SEND   = 3'd4,
    PH_RACK   = 3'd5,
    PH_RNACK  = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_START = 3'd1,
    ACT_SEND  = 3'd2,
    ACT_RACK  = 3'd3,
    ACT_RNACK = 3'd4,
    ACT_STOP  = 3'd5
  } act_t;

endpackage : i2cm_pkg

`default_nettype wire

[hdl/i2cm_if.sv]
// i2cm_if: valid/ready channel interfaces of the I2C master register controller.
// Depends on i2cm_pkg for the field widths.
`default_nettype none

interface i2cm_in_if;
  import i2cm_pkg::*;
  logic            valid;
  logic            ready;
  logic [1:0]      op;
  logic [2:0]      reg_index;
  logic [RegW-1:0] write_data;
  logic            slave_ack;
  logic [RegW-1:0] slave_byte;

  modport source (output valid, op, reg_index, write_data, slave_ack, slave_byte,
                  input ready);
  modport sink   (input valid, op, reg_index, write_data, slave_ack, slave_byte,
                  output ready);
endinterface : i2cm_in_if

interface i2cm_out_if;
  import i2cm_pkg::*;
  logic            valid;
  logic            ready;
  logic [RegW-1:0] read_data;
  logic [2:0]      bus_action;
  logic [RegW-1:0] bus_byte;
  logic            irq_flag;

  modport source (output valid, read_data, bus_action, bus_byte, irq_flag,
                  input ready);
  modport sink   (input valid, read_data, bus_action, bus_byte, irq_flag,
                  output ready);
endinterface : i2cm_out_if

interface i2cm_cfg_if;
  import i2cm_pkg::*;
  logic             valid;
  logic             ready;
  logic [BaudW-1:0] baud_divider;

  modport source (output valid, baud_divider, input ready);
  modport sink   (input valid, baud_divider, output ready);
endinterface : i2cm_cfg_if

`default_nettype wire

[hdl/i2c_master_register_controller.sv]
// i2c_master_register_controller: master-only I2C controller at its register level.
// Depends on i2cm_pkg and the channel interfaces in i2cm_if.sv.
//
// Usage:
//  - in_ch carries one beat per register write (op 0), register read (op 1)
//    or bus phase completion (op 2, with slave_ack and slave_byte).
//  - out_ch returns exactly one beat per input beat: read_data for reads,
//    bus_action/bus_byte telling the bus engine what to do next, and the
//    interrupt flag as it stands after the beat.
//  - cfg_ch writes the SCL divider (M in bits 6..3, N in bits 2..0); it is
//    always ready and should be written only while the block is idle.
// Output: a result is registered and appears on out_ch in the cycle after its input beat.
// Throughput: one beat per cycle while out_ch.ready is high; the register state is
//   updated in the accept cycle so the next beat sees it right away.
// Stall: the output register holds its beat while out_ch.ready is low;
//   in_ch.ready is high whenever that register is empty or being drained,
//   so a new beat is taken in the same cycle the old one leaves.
// Reset (rst_n low, synchronous): control and data cleared, status 0xF8,
//   bus phase idle, divider zero, output register empty.
`default_nettype none

module i2c_master_register_controller
  import i2cm_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  i2cm_in_if.sink    in_ch,
  i2cm_out_if.source out_ch,
  i2cm_cfg_if.sink   cfg_ch
);

  // ---------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------
  logic [BaudW-1:0] baud_r;
  logic [RegW-1:0]  ctl_r, ctl_nxt;
  logic [RegW-1:0]  data_r, data_nxt;
  logic [RegW-1:0]  stat_r, stat_nxt;
  phase_t           phase_r, phase_nxt;
  logic             rdir_r, rdir_nxt;
  logic             busy_r, busy_nxt;

  // output register
  logic             out_valid_r;
  logic [RegW-1:0]  rd_r;
  act_t             act_r;
  logic [RegW-1:0]  byte_r;
  logic             irq_r;

  // per-beat results
  logic [RegW-1:0]  rd_c;
  act_t             act_c;
  logic [RegW-1:0]  byte_c;
  logic             in_acc;
  logic             old_iflg;
  op_t              op_c;

  assign in_ch.ready = ~out_valid_r | out_ch.ready;
  assign in_acc      = in_ch.valid & in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign op_c        = op_t'(in_ch.op);
  assign old_iflg    = ctl_r[CTL_IFLG];

  // ---------------------------------------------------------------------
  // Next-state and result logic: one pass per accepted beat
  // ---------------------------------------------------------------------
  always_comb begin
    ctl_nxt   = ctl_r;
    data_nxt  = data_r;
    stat_nxt  = stat_r;
    phase_nxt = phase_r;
    rdir_nxt  = rdir_r;
    busy_nxt  = busy_r;
    rd_c      = '0;
    act_c     = ACT_NONE;
    byte_c    = '0;

    if (in_acc) begin
      unique case (op_c)
        OP_WRITE: begin
          if (in_ch.reg_index == IDX_DATA) begin
            data_nxt = in_ch.write_data;
          end else if (in_ch.reg_index == IDX_CTRL) begin
            // IFLG can only be cleared by software, never set
            ctl_nxt = in_ch.write_data;
            ctl_nxt[CTL_IFLG] = old_iflg & in_ch.write_data[CTL_IFLG];
            if (!busy_r && !ctl_nxt[CTL_IFLG]) begin
              priority if (ctl_nxt[CTL_STOP]) begin
                ctl_nxt[CTL_STOP] = 1'b0;
                if (phase_r != PH_IDLE) begin
                  phase_nxt = PH_IDLE;
                  stat_nxt  = ST_IDLE;
                  act_c     = ACT_STOP;
                end
              end else if (ctl_nxt[CTL_START]) begin
                ctl_nxt[CTL_START] = 1'b0;
                phase_nxt = (phase_r == PH_IDLE) ? PH_START : PH_RSTART;
                busy_nxt  = 1'b1;
                act_c     = ACT_START;
              end else if (old_iflg && phase_r != PH_IDLE) begin
                // byte phase released by clearing IFLG
                busy_nxt = 1'b1;
                if (phase_r == PH_START || phase_r == PH_RSTART) begin
                  rdir_nxt  = data_r[0];
                  phase_nxt = PH_ADDR;
                  act_c     = ACT_SEND;
                  byte_c    = data_r;
                end else if (rdir_r) begin
                  if (ctl_nxt[CTL_ACK]) begin
                    phase_nxt = PH_RACK;
                    act_c     = ACT_RACK;
                  end else begin
                    phase_nxt = PH_RNACK;
                    act_c     = ACT_RNACK;
                  end
                end else begin
                  phase_nxt = PH_SEND;
                  act_c     = ACT_SEND;
                  byte_c    = data_r;
                end
              end else begin
                // nothing to launch
              end
            end
          end else if (in_ch.reg_index == IDX_SRST) begin
            ctl_nxt   = '0;
            data_nxt  = '0;
            stat_nxt  = ST_IDLE;
            phase_nxt = PH_IDLE;
            rdir_nxt  = 1'b0;
            busy_nxt  = 1'b0;
          end
        end
        OP_READ: begin
          if (in_ch.reg_index == IDX_DATA) begin
            rd_c = data_r;
          end else if (in_ch.reg_index == IDX_CTRL) begin
            rd_c = ctl_r;
          end else if (in_ch.reg_index == IDX_STAT) begin
            rd_c = stat_r;
          end
        end
        OP_DONE: begin
          // completion with nothing in flight is dropped
          if (busy_r) begin
            busy_nxt          = 1'b0;
            ctl_nxt[CTL_IFLG] = 1'b1;
            unique case (phase_r)
              PH_START:  stat_nxt = ST_START;
              PH_RSTART: stat_nxt = ST_RSTART;
              PH_ADDR: begin
                if (rdir_r) stat_nxt = in_ch.slave_ack ? ST_ADDR_R : ST_ADDR_RN;
                else        stat_nxt = in_ch.slave_ack ? ST_ADDR_W : ST_ADDR_WN;
              end
              PH_SEND:   stat_nxt = in_ch.slave_ack ? ST_DATA_W : ST_DATA_WN;
              PH_RACK: begin
                data_nxt = in_ch.slave_byte;
                stat_nxt = ST_DATA_R;
              end
              PH_RNACK: begin
                data_nxt = in_ch.slave_byte;
                stat_nxt = ST_DATA_RN;
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      baud_r      <= '0;
      ctl_r       <= '0;
      data_r      <= '0;
      stat_r      <= ST_IDLE;
      phase_r     <= PH_IDLE;
      rdir_r      <= 1'b0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        baud_r <= cfg_ch.baud_divider;
      end
      ctl_r   <= ctl_nxt;
      data_r  <= data_nxt;
      stat_r  <= stat_nxt;
      phase_r <= phase_nxt;
      rdir_r  <= rdir_nxt;
      busy_r  <= busy_nxt;
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded on accept only
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_r   <= rd_c;
      act_r  <= act_c;
      byte_r <= byte_c;
      irq_r  <= ctl_nxt[CTL_IFLG];
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_data  = rd_r;
  assign out_ch.bus_action = act_r;
  assign out_ch.bus_byte   = byte_r;
  assign out_ch.irq_flag   = irq_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_busy_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (phase_r != PH_IDLE))
    else $error("phase in flight while bus phase is idle");

  a_idle_status: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (stat_r == ST_IDLE))
    else $error("idle bus phase with non-idle status");

  a_launch_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (act_c == ACT_START || act_c == ACT_SEND ||
                act_c == ACT_RACK || act_c == ACT_RNACK)) |=> busy_r)
    else $error("bus phase launched without going busy");

  a_done_iflg: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && op_c == OP_DONE && busy_r) |=> (ctl_r[CTL_IFLG] && !busy_r))
    else $error("completion did not raise IFLG");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ch.ready)
    else $error("input stalled with empty output register");

endmodule : i2c_master_register_controller

`default_nettype wire
